### sv/lom_pkg.sv
// Shared types and codes for the limit order matcher.
`default_nettype none
package lom_pkg;

  typedef enum logic [1:0] {
    ST_RESTED  = 2'd0,
    ST_FILLED  = 2'd1,
    ST_DROPPED = 2'd2,
    ST_CANCEL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_INSERT = 2'd2,
    OP_SETQ   = 2'd3
  } op_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] tm;
    logic [23:0] px;
    logic [31:0] qty;
  } entry_t;

  // running best candidate handed along the cell chain
  typedef struct packed {
    logic        found;
    logic [23:0] px;
    logic [31:0] tm;
  } best_t;

  typedef struct packed {
    op_t    op;
    logic   ask;
    logic [31:0] id;
    entry_t ent;
  } cmd_t;

endpackage
`default_nettype wire

### sv/lom_cell.sv
// One book slot per side plus one stage of the best-order scan chain.
`default_nettype none
module lom_cell #(
  parameter int IW = 5
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lom_pkg::cmd_t   cmd,
  input  wire logic            sel,
  input  wire logic [IW-1:0]   my_idx,
  input  wire logic            scan_ask,
  input  wire logic            go_in,
  input  wire lom_pkg::best_t  best_in,
  input  wire logic [IW-1:0]   idx_in,
  output logic                 go_out,
  output lom_pkg::best_t       best_out,
  output logic [IW-1:0]        idx_out,
  output logic                 bid_v,
  output logic                 ask_v,
  output lom_pkg::entry_t      bid_e,
  output lom_pkg::entry_t      ask_e
);

  logic            v;
  lom_pkg::entry_t e;
  logic            take;

  always_comb begin
    v = scan_ask ? ask_v : bid_v;
    e = scan_ask ? ask_e : bid_e;
    take = 1'b0;
    if (v) begin
      if (!best_in.found) begin
        take = 1'b1;
      end else if (e.px == best_in.px) begin
        take = e.tm < best_in.tm;
      end else if (scan_ask) begin
        take = e.px < best_in.px;
      end else begin
        take = e.px > best_in.px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bid_v  <= 1'b0;
      ask_v  <= 1'b0;
      go_out <= 1'b0;
    end else begin
      go_out <= go_in;
      unique case (cmd.op)
        lom_pkg::OP_CANCEL: begin
          if (bid_v && bid_e.id == cmd.id) bid_v <= 1'b0;
          if (ask_v && ask_e.id == cmd.id) ask_v <= 1'b0;
        end
        lom_pkg::OP_INSERT: begin
          if (sel && cmd.ask) ask_v <= 1'b1;
          if (sel && !cmd.ask) bid_v <= 1'b1;
        end
        lom_pkg::OP_SETQ: begin
          if (sel && cmd.ask && cmd.ent.qty == 32'd0) ask_v <= 1'b0;
          if (sel && !cmd.ask && cmd.ent.qty == 32'd0) bid_v <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_out <= '{found: 1'b1, px: e.px, tm: e.tm};
      idx_out  <= my_idx;
    end else begin
      best_out <= best_in;
      idx_out  <= idx_in;
    end
    if (sel && cmd.op == lom_pkg::OP_INSERT) begin
      if (cmd.ask) ask_e <= cmd.ent;
      else bid_e <= cmd.ent;
    end
    if (sel && cmd.op == lom_pkg::OP_SETQ) begin
      if (cmd.ask) ask_e.qty <= cmd.ent.qty;
      else bid_e.qty <= cmd.ent.qty;
    end
  end

endmodule
`default_nettype wire

### sv/lom_ctrl.sv
// Order sequencer: cancel, scan, fill, rest, and the output register.
`default_nettype none
module lom_ctrl #(
  parameter int DEPTH = 32,
  parameter int IW    = 5
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [31:0]     order_ref,
  input  wire logic [31:0]     timestamp,
  input  wire logic [23:0]     price,
  input  wire logic [31:0]     quantity,
  input  wire logic            is_ask,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 is_deal,
  output logic [31:0]          bid_id,
  output logic [31:0]          ask_id,
  output logic [31:0]          deal_quantity,
  output logic [55:0]          deal_value,
  output logic [1:0]           end_status,
  output logic                 last_item,
  output lom_pkg::cmd_t        cmd,
  output logic [DEPTH-1:0]     sel,
  output logic                 scan_ask,
  output logic                 go,
  input  wire logic            last_go,
  input  wire lom_pkg::best_t  last_best,
  input  wire logic [IW-1:0]   last_idx,
  input  wire logic [DEPTH-1:0] bid_v,
  input  wire logic [DEPTH-1:0] ask_v,
  input  wire lom_pkg::entry_t bid_e [DEPTH],
  input  wire lom_pkg::entry_t ask_e [DEPTH]
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CANCEL, S_START, S_SCAN, S_CHECK, S_MUL, S_EMIT, S_PLACE, S_STATUS
  } state_t;

  state_t           state;
  logic [31:0]      id_r, ts_r, rem;
  logic [23:0]      px_r;
  logic             sell;
  logic [CW-1:0]    n;
  logic             bfound;
  logic [23:0]      bpx;
  logic [IW-1:0]    bidx;
  logic [31:0]      q_r, rq_r, oid_r;
  logic [23:0]      lvl_r;
  logic [55:0]      sum_r, prod;
  lom_pkg::status_t status_r;
  logic             can_load;
  logic             load_out;
  logic [31:0]      rq, slot_id;
  logic             free;
  logic [IW-1:0]    fidx;
  logic [DEPTH-1:0] own_v;

  assign scan_ask = ~sell;
  assign in_stall = state != S_IDLE;
  assign can_load = !out_valid || !out_stall;
  assign load_out = (state == S_EMIT || state == S_STATUS) && can_load;
  assign prod     = 56'(q_r) * 56'(lvl_r);
  assign rq       = scan_ask ? ask_e[bidx].qty : bid_e[bidx].qty;
  assign slot_id  = scan_ask ? ask_e[bidx].id : bid_e[bidx].id;
  assign own_v    = sell ? ask_v : bid_v;
  assign go       = state == S_START && rem != 32'd0 && n != CW'(DEPTH);

  always_comb begin
    free = 1'b0;
    fidx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!own_v[i]) begin
        free = 1'b1;
        fidx = IW'(i);
      end
    end
  end

  always_comb begin
    cmd = '{op: lom_pkg::OP_NOP, ask: sell, id: id_r,
            ent: '{id: id_r, tm: ts_r, px: px_r, qty: rem}};
    sel = '0;
    unique case (state)
      S_CANCEL: cmd.op = lom_pkg::OP_CANCEL;
      S_MUL: begin
        cmd.op      = lom_pkg::OP_SETQ;
        cmd.ask     = scan_ask;
        cmd.ent.qty = rq_r - q_r;
        sel[bidx]   = 1'b1;
      end
      S_PLACE: begin
        if (free) begin
          cmd.op    = lom_pkg::OP_INSERT;
          sel[fidx] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !load_out) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            id_r  <= order_ref;
            ts_r  <= timestamp;
            px_r  <= price;
            rem   <= quantity;
            sell  <= is_ask;
            state <= S_CANCEL;
          end
        end
        S_CANCEL: begin
          n <= '0;
          if (rem == 32'd0) begin
            status_r <= lom_pkg::ST_CANCEL;
            state    <= S_STATUS;
          end else begin
            state <= S_START;
          end
        end
        S_START: begin
          if (rem == 32'd0) begin
            status_r <= lom_pkg::ST_FILLED;
            state    <= S_STATUS;
          end else if (n == CW'(DEPTH)) begin
            state <= S_PLACE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last_go) begin
            bfound <= last_best.found;
            bpx    <= last_best.px;
            bidx   <= last_idx;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!bfound || (sell ? bpx < px_r : bpx > px_r)) begin
            state <= S_PLACE;
          end else begin
            q_r   <= rem < rq ? rem : rq;
            rq_r  <= rq;
            lvl_r <= bpx;
            oid_r <= slot_id;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          sum_r <= prod;
          rem   <= rem - q_r;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (can_load) begin
            out_valid     <= 1'b1;
            is_deal       <= 1'b1;
            bid_id        <= sell ? oid_r : id_r;
            ask_id        <= sell ? id_r : oid_r;
            deal_quantity <= q_r;
            deal_value    <= sum_r;
            end_status    <= lom_pkg::ST_RESTED;
            last_item     <= 1'b0;
            n             <= n + CW'(1);
            state         <= S_START;
          end
        end
        S_PLACE: begin
          status_r <= free ? lom_pkg::ST_RESTED : lom_pkg::ST_DROPPED;
          state    <= S_STATUS;
        end
        S_STATUS: begin
          if (can_load) begin
            out_valid     <= 1'b1;
            is_deal       <= 1'b0;
            bid_id        <= '0;
            ask_id        <= '0;
            deal_quantity <= '0;
            deal_value    <= '0;
            end_status    <= status_r;
            last_item     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/limit_order_matcher_top.sv
// Top level: sequencer plus a chain of book cells.
//
//  channel | direction | handshake           | beat
//  in      | to block  | in_valid / in_stall   | one order
//  out     | from block| out_valid / out_stall | one fill or closing status
//
// A cancel-only order passes the cancel and status states; a filled one
// passes cancel, then start, scan, check, mul and emit per fill, then start
// and status. An order that rests or is dropped adds one scan that finds no
// crossing order, then place (no scan once SIDE_DEPTH fills are done). The
// best-order scan walks the cell chain one cell per cycle. Reset clears all
// slot valid bits at once. Output stalls hold the sequencer; no new order is
// taken until the closing status beat is loaded into the output register.
`default_nettype none
module limit_order_matcher_top #(
  parameter int SIDE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] order_ref,
  input  wire logic [31:0] timestamp,
  input  wire logic [23:0] price,
  input  wire logic [31:0] quantity,
  input  wire logic        is_ask,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_deal,
  output logic [31:0]      bid_id,
  output logic [31:0]      ask_id,
  output logic [31:0]      deal_quantity,
  output logic [55:0]      deal_value,
  output logic [1:0]       end_status,
  output logic             last_item
);

  localparam int IW = $clog2(SIDE_DEPTH);

  lom_pkg::cmd_t         cmd;
  logic [SIDE_DEPTH-1:0] sel;
  logic                  scan_ask;
  logic                  go;
  logic [SIDE_DEPTH:0]   go_c;
  lom_pkg::best_t        best_c [SIDE_DEPTH+1];
  logic [IW-1:0]         idx_c  [SIDE_DEPTH+1];
  logic [SIDE_DEPTH-1:0] bid_v, ask_v;
  lom_pkg::entry_t       bid_e [SIDE_DEPTH];
  lom_pkg::entry_t       ask_e [SIDE_DEPTH];

  assign go_c[0]   = go;
  assign best_c[0] = '{found: 1'b0, px: '0, tm: '0};
  assign idx_c[0]  = '0;

  for (genvar g = 0; g < SIDE_DEPTH; g++) begin : g_cell
    lom_cell #(.IW(IW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .sel      (sel[g]),
      .my_idx   (IW'(g)),
      .scan_ask (scan_ask),
      .go_in    (go_c[g]),
      .best_in  (best_c[g]),
      .idx_in   (idx_c[g]),
      .go_out   (go_c[g+1]),
      .best_out (best_c[g+1]),
      .idx_out  (idx_c[g+1]),
      .bid_v    (bid_v[g]),
      .ask_v    (ask_v[g]),
      .bid_e    (bid_e[g]),
      .ask_e    (ask_e[g])
    );
  end

  lom_ctrl #(.DEPTH(SIDE_DEPTH), .IW(IW)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .order_ref     (order_ref),
    .timestamp     (timestamp),
    .price         (price),
    .quantity      (quantity),
    .is_ask        (is_ask),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_deal       (is_deal),
    .bid_id        (bid_id),
    .ask_id        (ask_id),
    .deal_quantity (deal_quantity),
    .deal_value    (deal_value),
    .end_status    (end_status),
    .last_item     (last_item),
    .cmd           (cmd),
    .sel           (sel),
    .scan_ask      (scan_ask),
    .go            (go),
    .last_go       (go_c[SIDE_DEPTH]),
    .last_best     (best_c[SIDE_DEPTH]),
    .last_idx      (idx_c[SIDE_DEPTH]),
    .bid_v         (bid_v),
    .ask_v         (ask_v),
    .bid_e         (bid_e),
    .ask_e         (ask_e)
  );

endmodule
`default_nettype wire

### sv/lom_check.sv
// Port-level checker for the matcher, bound to the top level.
`default_nettype none
module lom_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        is_deal,
  input wire logic [31:0] deal_quantity,
  input wire logic [55:0] deal_value,
  input wire logic [1:0]  end_status,
  input wire logic        last_item
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("out beat dropped");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_deal |-> last_item) else $error("status without last");

  a_fill_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_deal |-> !last_item && end_status == 2'd0)
    else $error("fill beat fields");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_deal |-> deal_quantity == 32'd0 && deal_value == 56'd0)
    else $error("status beat fields");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("order taken while busy");

endmodule

bind limit_order_matcher_top lom_check u_lom_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .is_deal       (is_deal),
  .deal_quantity (deal_quantity),
  .deal_value    (deal_value),
  .end_status    (end_status),
  .last_item     (last_item)
);
`default_nettype wire

### tb/sv/tb_limit_order_matcher_top.sv
// Self-checking bench for the limit order matcher: book predictor, driver and monitor.
`default_nettype none
module tb_limit_order_matcher_top;

  localparam int DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] ts;
    logic [23:0] px;
    logic [31:0] qty;
    logic        ask;
  } order_t;

  typedef struct packed {
    logic        deal;
    logic [31:0] bid;
    logic [31:0] ask;
    logic [31:0] qty;
    logic [55:0] sum;
    logic [1:0]  status;
    logic        last;
  } fill_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] order_ref = '0;
  logic [31:0] timestamp = '0;
  logic [23:0] price = '0;
  logic [31:0] quantity = '0;
  logic is_ask = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic is_deal;
  logic [31:0] bid_id, ask_id, deal_quantity;
  logic [55:0] deal_value;
  logic [1:0] end_status;
  logic last_item;

  limit_order_matcher_top #(.SIDE_DEPTH(DEPTH)) u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the book
  logic        bk_v  [2][DEPTH];
  logic [31:0] bk_id [2][DEPTH];
  logic [31:0] bk_ts [2][DEPTH];
  logic [23:0] bk_px [2][DEPTH];
  logic [31:0] bk_q  [2][DEPTH];

  order_t pending_orders[$];
  fill_t  expected_fills[$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_sender = 1'b0;
  int     errors = 0;
  int     quiet_cycles = 0;
  bit     stim_done = 1'b0;

  function automatic int best_resting(int sd);
    int b;
    logic better;
    b = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (!bk_v[sd][i]) continue;
      if (b < 0) begin
        b = i;
        continue;
      end
      if (bk_px[sd][i] == bk_px[sd][b]) better = bk_ts[sd][i] < bk_ts[sd][b];
      else if (sd == 1) better = bk_px[sd][i] < bk_px[sd][b];
      else better = bk_px[sd][i] > bk_px[sd][b];
      if (better) b = i;
    end
    return b;
  endfunction

  task automatic match_order(order_t o);
    logic [31:0] rem, q;
    int opp, s, n, slot;
    fill_t f;
    rem = o.qty;
    n = 0;
    opp = o.ask ? 0 : 1;
    for (int sd = 0; sd < 2; sd++)
      for (int i = 0; i < DEPTH; i++)
        if (bk_v[sd][i] && bk_id[sd][i] == o.id) bk_v[sd][i] = 1'b0;
    if (rem == 0) begin
      expected_fills.push_back('{1'b0, 32'd0, 32'd0, 32'd0, 56'd0, lom_pkg::ST_CANCEL, 1'b1});
      return;
    end
    while (rem != 0 && n < DEPTH) begin
      s = best_resting(opp);
      if (s < 0) break;
      if (o.ask ? (bk_px[opp][s] < o.px) : (bk_px[opp][s] > o.px)) break;
      q = rem < bk_q[opp][s] ? rem : bk_q[opp][s];
      rem -= q;
      bk_q[opp][s] -= q;
      f.deal = 1'b1;
      f.bid = o.ask ? bk_id[opp][s] : o.id;
      f.ask = o.ask ? o.id : bk_id[opp][s];
      f.qty = q;
      f.sum = 56'(q) * 56'(bk_px[opp][s]);
      f.status = lom_pkg::ST_RESTED;
      f.last = 1'b0;
      expected_fills.push_back(f);
      n++;
      if (bk_q[opp][s] == 0) bk_v[opp][s] = 1'b0;
    end
    if (rem == 0) begin
      expected_fills.push_back('{1'b0, 32'd0, 32'd0, 32'd0, 56'd0, lom_pkg::ST_FILLED, 1'b1});
      return;
    end
    slot = -1;
    for (int i = 0; i < DEPTH; i++)
      if (!bk_v[o.ask][i]) begin
        slot = i;
        break;
      end
    if (slot >= 0) begin
      bk_v[o.ask][slot] = 1'b1;
      bk_id[o.ask][slot] = o.id;
      bk_ts[o.ask][slot] = o.ts;
      bk_px[o.ask][slot] = o.px;
      bk_q[o.ask][slot] = rem;
    end
    expected_fills.push_back('{1'b0, 32'd0, 32'd0, 32'd0, 56'd0,
                               slot >= 0 ? lom_pkg::ST_RESTED : lom_pkg::ST_DROPPED, 1'b1});
  endtask

  // driver
  always @(posedge clk) begin
    order_t o;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) match_order({order_ref, timestamp, price, quantity, is_ask});
      if (!in_valid || !in_stall) begin
        if (pending_orders.size() != 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          o = pending_orders.pop_front();
          in_valid <= 1'b1;
          order_ref <= o.id;
          timestamp <= o.ts;
          price <= o.px;
          quantity <= o.qty;
          is_ask <= o.ask;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    fill_t e;
    if (!rst) begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_fills.size() == 0) begin
          $error("unexpected beat");
          errors++;
        end else begin
          e = expected_fills.pop_front();
          if (is_deal !== e.deal) begin
            $error("is_deal exp %0h got %0h", e.deal, is_deal); errors++;
          end
          if (bid_id !== e.bid) begin
            $error("bid_id exp %0h got %0h", e.bid, bid_id); errors++;
          end
          if (ask_id !== e.ask) begin
            $error("ask_id exp %0h got %0h", e.ask, ask_id); errors++;
          end
          if (deal_quantity !== e.qty) begin
            $error("deal_quantity exp %0h got %0h", e.qty, deal_quantity); errors++;
          end
          if (deal_value !== e.sum) begin
            $error("deal_value exp %0h got %0h", e.sum, deal_value); errors++;
          end
          if (end_status !== e.status) begin
            $error("end_status exp %0h got %0h", e.status, end_status); errors++;
          end
          if (last_item !== e.last) begin
            $error("last_item exp %0h got %0h", e.last, last_item); errors++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic order_t mk(logic [31:0] id, logic [31:0] ts, logic [23:0] px,
                                logic [31:0] q, logic a);
    order_t o;
    o = '{id, ts, px, q, a};
    return o;
  endfunction

  logic [31:0] ts_next = 32'd100;

  // random order from a small id/price pool so that cancels and crosses happen
  function automatic order_t rand_order();
    order_t o;
    int r;
    r = $urandom_range(99);
    o.id = (r < 80) ? $urandom_range(60) : $urandom;
    o.ts = (r < 90) ? ts_next : $urandom;
    ts_next += $urandom_range(3);
    o.px = (r < 85) ? 24'(1000 + $urandom_range(20)) : 24'($urandom);
    case ($urandom_range(9))
      0: o.qty = 32'd0;
      1: o.qty = $urandom;
      default: o.qty = $urandom_range(1, 50);
    endcase
    o.ask = 1'($urandom_range(1));
    return o;
  endfunction

  task automatic drain();
    while (pending_orders.size() != 0 || expected_fills.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  initial begin
    for (int sd = 0; sd < 2; sd++)
      for (int i = 0; i < DEPTH; i++) bk_v[sd][i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, cancel, price-time ties, deep sweep
    pending_orders.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    pending_orders.push_back(mk(32'd0, 32'd0, 24'd0, 32'hFFFF_FFFF, 1'b1));
    pending_orders.push_back(mk(32'd7, 32'd1, 24'd0, 32'd0, 1'b0));
    pending_orders.push_back(mk(32'hFFFF_FFFF, 32'd2, 24'd5, 32'd0, 1'b1));
    pending_orders.push_back(mk(32'd10, 32'd20, 24'd50, 32'd5, 1'b1));
    pending_orders.push_back(mk(32'd11, 32'd20, 24'd50, 32'd5, 1'b1));
    pending_orders.push_back(mk(32'd12, 32'd10, 24'd50, 32'd5, 1'b1));
    pending_orders.push_back(mk(32'd13, 32'd30, 24'd40, 32'd5, 1'b1));
    pending_orders.push_back(mk(32'd12, 32'd31, 24'd60, 32'd3, 1'b1));
    pending_orders.push_back(mk(32'd20, 32'd40, 24'd49, 32'd4, 1'b0));
    pending_orders.push_back(mk(32'd21, 32'd41, 24'd55, 32'd30, 1'b0));
    pending_orders.push_back(mk(32'd22, 32'd42, 24'd1, 32'd1, 1'b1));
    pending_orders.push_back(mk(32'd999, 32'd43, 24'd1, 32'd0, 1'b0));
    drain();

    // fill the bid side, overflow it, then sweep it with one sell
    for (int i = 0; i < DEPTH + 2; i++)
      pending_orders.push_back(mk(32'(200 + i), 32'(500 + i), 24'(100 + i % 4), 32'd2, 1'b0));
    pending_orders.push_back(mk(32'd300, 32'd600, 24'd0, 32'hFFFF_FFFF, 1'b1));
    pending_orders.push_back(mk(32'd300, 32'd601, 24'd0, 32'd0, 1'b1));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        3: begin send_idle_pct = 24; recv_stall_pct = 24; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int k = 0; k < 65; k++) pending_orders.push_back(rand_order());
      // sender holds off until every expected beat is back
      if (ph == 3) begin
        while (pending_orders.size() > 30) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_fills.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_fills.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
